// File: src/depth_hue_colorizer_unit_macros.svh
// Assertion macros for the depth hue colorizer.
// Used by the top level; compiled away when SYNTHESIS is defined.
`ifndef DEPTH_HUE_COLORIZER_UNIT_MACROS_SVH
`define DEPTH_HUE_COLORIZER_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// Checked only while out of reset.
`define DHC_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("dhc assertion failed");
// Checked on every edge, reset included.
`define DHC_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("dhc assertion failed");
`else
`define DHC_ASSERT(lbl, clk, rstn, prop)
`define DHC_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// File: src/dhc_pkg.sv
// Shared types, constants and window tables of the depth hue colorizer.
// No dependencies.
package dhc_pkg;

  typedef logic [15:0] depth_t;
  typedef logic [7:0]  chan_t;
  typedef logic [12:0] mm_t;
  typedef logic [20:0] prod_t;

  typedef enum logic [1:0] {
    MODE_NARROW_BINNED   = 2'd0,
    MODE_NARROW_UNBINNED = 2'd1,
    MODE_WIDE_BINNED     = 2'd2,
    MODE_WIDE_UNBINNED   = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    SEC_RED_UP   = 3'd0,
    SEC_RED_DOWN = 3'd1,
    SEC_BLUE_UP  = 3'd2,
    SEC_GRN_DOWN = 3'd3,
    SEC_RED_RISE = 3'd4
  } sector_t;

  localparam chan_t CH_MAX      = 8'hFF;
  localparam int    RECIP_SHIFT = 24;

  localparam int SPAN_NB = 5800 - 500;
  localparam int SPAN_NU = 4000 - 500;
  localparam int SPAN_WB = 3000 - 250;
  localparam int SPAN_WU = 2500 - 250;

  localparam int RECIP_NB = (1 << RECIP_SHIFT) / SPAN_NB;
  localparam int RECIP_NU = (1 << RECIP_SHIFT) / SPAN_NU;
  localparam int RECIP_WB = (1 << RECIP_SHIFT) / SPAN_WB;
  localparam int RECIP_WU = (1 << RECIP_SHIFT) / SPAN_WU;

  // Payload between the window stages and the scaling stages.
  typedef struct packed {
    logic    zero;
    mode_t   mode;
    sector_t sector;
    prod_t   p255;
  } win_t;

  function automatic mm_t win_lo(mode_t m);
    mm_t v;
    unique case (m)
      MODE_NARROW_BINNED:   v = 13'd500;
      MODE_NARROW_UNBINNED: v = 13'd500;
      MODE_WIDE_BINNED:     v = 13'd250;
      MODE_WIDE_UNBINNED:   v = 13'd250;
      default:              v = 13'd500;
    endcase
    return v;
  endfunction

  function automatic mm_t win_hi(mode_t m);
    mm_t v;
    unique case (m)
      MODE_NARROW_BINNED:   v = 13'd5800;
      MODE_NARROW_UNBINNED: v = 13'd4000;
      MODE_WIDE_BINNED:     v = 13'd3000;
      MODE_WIDE_UNBINNED:   v = 13'd2500;
      default:              v = 13'd4000;
    endcase
    return v;
  endfunction

  function automatic mm_t span_of(mode_t m);
    mm_t v;
    unique case (m)
      MODE_NARROW_BINNED:   v = 13'(SPAN_NB);
      MODE_NARROW_UNBINNED: v = 13'(SPAN_NU);
      MODE_WIDE_BINNED:     v = 13'(SPAN_WB);
      MODE_WIDE_UNBINNED:   v = 13'(SPAN_WU);
      default:              v = 13'(SPAN_NU);
    endcase
    return v;
  endfunction

  // floor(2^RECIP_SHIFT / span)
  function automatic mm_t recip_of(mode_t m);
    mm_t v;
    unique case (m)
      MODE_NARROW_BINNED:   v = 13'(RECIP_NB);
      MODE_NARROW_UNBINNED: v = 13'(RECIP_NU);
      MODE_WIDE_BINNED:     v = 13'(RECIP_WB);
      MODE_WIDE_UNBINNED:   v = 13'(RECIP_WU);
      default:              v = 13'(RECIP_NU);
    endcase
    return v;
  endfunction

endpackage

// File: src/dhc_depth_if.sv
// Depth sample channel: valid/ready plus one 16-bit depth.
// Depends on dhc_pkg.
interface dhc_depth_if;
  logic            valid;
  logic            ready;
  dhc_pkg::depth_t depth;

  modport source(output valid, output depth, input ready);
  modport sink(input valid, input depth, output ready);
endinterface

// File: src/dhc_rgb_if.sv
// Color result channel: valid/ready plus red, green and blue.
// Depends on dhc_pkg.
interface dhc_rgb_if;
  logic           valid;
  logic           ready;
  dhc_pkg::chan_t red;
  dhc_pkg::chan_t green;
  dhc_pkg::chan_t blue;

  modport source(output valid, output red, output green, output blue, input ready);
  modport sink(input valid, input red, input green, input blue, output ready);
endinterface

// File: src/dhc_window.sv
// Stages 1-2: clamp to the mode window, find the hue sector and 255*remainder.
// Depends on dhc_pkg and dhc_depth_if.
module dhc_window (
  input  logic               clk,
  input  logic               rst_n,
  input  dhc_pkg::mode_t     range_sel,
  dhc_depth_if.sink          in_ch,
  output logic               win_valid,
  output dhc_pkg::win_t      win_data,
  input  logic               win_ready
);

  logic                s1_v_r;
  dhc_pkg::mm_t        s1_x_r;
  logic                s1_zero_r;
  dhc_pkg::mode_t      s1_mode_r;
  logic                s2_v_r;
  dhc_pkg::win_t       s2_data_r;

  logic                s1_ready;
  logic                s2_ready;
  dhc_pkg::mm_t        lo;
  dhc_pkg::mm_t        hi;
  dhc_pkg::mm_t        clamped;
  dhc_pkg::mm_t        span;
  logic [14:0]         n;
  logic [14:0]         span1;
  logic [14:0]         span2;
  logic [14:0]         span3;
  logic [14:0]         span4;
  logic [14:0]         base;
  dhc_pkg::sector_t    sector;
  dhc_pkg::mm_t        rem;
  dhc_pkg::win_t       s2_data_nxt;

  assign s2_ready    = !s2_v_r || win_ready;
  assign s1_ready    = !s1_v_r || s2_ready;
  assign in_ch.ready = s1_ready;

  // stage 1: clamp
  always_comb begin
    lo = dhc_pkg::win_lo(range_sel);
    hi = dhc_pkg::win_hi(range_sel);
    if (in_ch.depth > 16'(hi)) begin
      clamped = hi;
    end else if (in_ch.depth < 16'(lo)) begin
      clamped = lo;
    end else begin
      clamped = in_ch.depth[12:0];
    end
  end

  // stage 2: sector and remainder
  always_comb begin
    span  = dhc_pkg::span_of(s1_mode_r);
    n     = {s1_x_r, 2'b00};
    span1 = 15'(span);
    span2 = {1'b0, span, 1'b0};
    span3 = span1 + span2;
    span4 = {span, 2'b00};
    priority if (n >= span4) begin
      sector = dhc_pkg::SEC_RED_RISE;
      base   = span4;
    end else if (n >= span3) begin
      sector = dhc_pkg::SEC_GRN_DOWN;
      base   = span3;
    end else if (n >= span2) begin
      sector = dhc_pkg::SEC_BLUE_UP;
      base   = span2;
    end else if (n >= span1) begin
      sector = dhc_pkg::SEC_RED_DOWN;
      base   = span1;
    end else begin
      sector = dhc_pkg::SEC_RED_UP;
      base   = '0;
    end
    rem                = 13'(n - base);
    s2_data_nxt.zero   = s1_zero_r;
    s2_data_nxt.mode   = s1_mode_r;
    s2_data_nxt.sector = sector;
    s2_data_nxt.p255   = {rem, 8'h00} - 21'(rem);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      if (s1_ready) s1_v_r <= in_ch.valid;
      if (s2_ready) s2_v_r <= s1_v_r;
    end
    if (s1_ready && in_ch.valid) begin
      s1_x_r    <= hi - clamped;
      s1_zero_r <= (in_ch.depth == '0);
      s1_mode_r <= range_sel;
    end
    if (s2_ready && s1_v_r) begin
      s2_data_r <= s2_data_nxt;
    end
  end

  assign win_valid = s2_v_r;
  assign win_data  = s2_data_r;

endmodule

// File: src/dhc_scale.sv
// Stages 3-5: divide 255*remainder by the span via a reciprocal, then pick channels.
// Depends on dhc_pkg and dhc_rgb_if.
module dhc_scale (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          win_valid,
  input  dhc_pkg::win_t win_data,
  output logic          win_ready,
  dhc_rgb_if.source     out_ch
);

  typedef struct packed {
    logic             zero;
    dhc_pkg::mode_t   mode;
    dhc_pkg::sector_t sector;
    dhc_pkg::prod_t   p255;
    dhc_pkg::chan_t   t_est;
  } quot_t;

  typedef struct packed {
    logic             zero;
    dhc_pkg::mode_t   mode;
    dhc_pkg::sector_t sector;
    dhc_pkg::prod_t   p255;
    dhc_pkg::chan_t   t_est;
    dhc_pkg::prod_t   back;
  } back_t;

  logic           s3_v_r;
  quot_t          s3_r;
  logic           s4_v_r;
  back_t          s4_r;
  logic           s5_v_r;
  dhc_pkg::chan_t red_r;
  dhc_pkg::chan_t green_r;
  dhc_pkg::chan_t blue_r;

  logic           s3_ready;
  logic           s4_ready;
  logic           s5_ready;
  logic [33:0]    prod;
  quot_t          s3_nxt;
  back_t          s4_nxt;
  dhc_pkg::mm_t   span5;
  dhc_pkg::prod_t diff;
  logic           over;
  dhc_pkg::prod_t resid;
  dhc_pkg::chan_t t;
  dhc_pkg::chan_t q;
  dhc_pkg::chan_t red_nxt;
  dhc_pkg::chan_t green_nxt;
  dhc_pkg::chan_t blue_nxt;

  assign s5_ready  = !s5_v_r || out_ch.ready;
  assign s4_ready  = !s4_v_r || s5_ready;
  assign s3_ready  = !s3_v_r || s4_ready;
  assign win_ready = s3_ready;

  // stage 3: estimate, equal to the quotient or one below it
  always_comb begin
    prod          = 34'(win_data.p255) * 34'(dhc_pkg::recip_of(win_data.mode));
    s3_nxt.zero   = win_data.zero;
    s3_nxt.mode   = win_data.mode;
    s3_nxt.sector = win_data.sector;
    s3_nxt.p255   = win_data.p255;
    s3_nxt.t_est  = prod[dhc_pkg::RECIP_SHIFT +: 8];
  end

  // stage 4: multiply back
  always_comb begin
    s4_nxt.zero   = s3_r.zero;
    s4_nxt.mode   = s3_r.mode;
    s4_nxt.sector = s3_r.sector;
    s4_nxt.p255   = s3_r.p255;
    s4_nxt.t_est  = s3_r.t_est;
    s4_nxt.back   = 21'(s3_r.t_est) * 21'(dhc_pkg::span_of(s3_r.mode));
  end

  // stage 5: correct, then q = 255 - ceil(p/span)
  always_comb begin
    span5 = dhc_pkg::span_of(s4_r.mode);
    diff  = s4_r.p255 - s4_r.back;
    over  = diff >= 21'(span5);
    resid = over ? diff - 21'(span5) : diff;
    t     = over ? s4_r.t_est + 8'd1 : s4_r.t_est;
    q     = dhc_pkg::CH_MAX - t - 8'(resid != '0);
    unique case (s4_r.sector)
      dhc_pkg::SEC_RED_UP: begin
        red_nxt = dhc_pkg::CH_MAX; green_nxt = t;               blue_nxt = '0;
      end
      dhc_pkg::SEC_RED_DOWN: begin
        red_nxt = q;               green_nxt = dhc_pkg::CH_MAX; blue_nxt = '0;
      end
      dhc_pkg::SEC_BLUE_UP: begin
        red_nxt = '0;              green_nxt = dhc_pkg::CH_MAX; blue_nxt = t;
      end
      dhc_pkg::SEC_GRN_DOWN: begin
        red_nxt = '0;              green_nxt = q;               blue_nxt = dhc_pkg::CH_MAX;
      end
      default: begin
        red_nxt = t;               green_nxt = '0;              blue_nxt = dhc_pkg::CH_MAX;
      end
    endcase
    if (s4_r.zero) begin
      red_nxt   = '0;
      green_nxt = '0;
      blue_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
      s5_v_r <= 1'b0;
    end else begin
      if (s3_ready) s3_v_r <= win_valid;
      if (s4_ready) s4_v_r <= s3_v_r;
      if (s5_ready) s5_v_r <= s4_v_r;
    end
    if (s3_ready && win_valid) s3_r <= s3_nxt;
    if (s4_ready && s3_v_r) s4_r <= s4_nxt;
    if (s5_ready && s4_v_r) begin
      red_r   <= red_nxt;
      green_r <= green_nxt;
      blue_r  <= blue_nxt;
    end
  end

  assign out_ch.valid = s5_v_r;
  assign out_ch.red   = red_r;
  assign out_ch.green = green_r;
  assign out_ch.blue  = blue_r;

endmodule

// File: src/depth_hue_colorizer_unit.sv
// Top level of the depth hue colorizer: mode register, window and scale pipelines.
// Depends on dhc_pkg, dhc_depth_if, dhc_rgb_if, dhc_window, dhc_scale and the macro header.
//
// Usage:
//   in_ch  carries one depth sample (mm) per item, valid/ready handshake.
//   out_ch carries one RGB item per input item, in order.
//   cfg_we/cfg_wdata write the 2-bit depth mode; write it only while the pipe is empty.
//   Depth zero gives black; other depths are clamped to the mode window and mapped
//   from blue (near) to red (far).
// Throughput: one item per clock unless out_ch.ready holds the pipe; five register stages
//   (clamp, sector, reciprocal multiply, multiply-back, correct and select).
// Reset: synchronous rst_n empties every stage and sets the mode to narrow unbinned.
// Stall: when out_ch.ready is low, items pack into the empty stages behind the
//   output register; in_ch.ready drops only when all five stages hold an item.
`include "depth_hue_colorizer_unit_macros.svh"

module depth_hue_colorizer_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [1:0] cfg_wdata,
  dhc_depth_if.sink  in_ch,
  dhc_rgb_if.source  out_ch
);

  dhc_pkg::mode_t range_sel_r;
  logic           win_valid;
  dhc_pkg::win_t  win_data;
  logic           win_ready;
  logic           rgb_has_zero;
  logic           rgb_has_full;
  logic           rgb_is_black;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_sel_r <= dhc_pkg::MODE_NARROW_UNBINNED;
    end else if (cfg_we) begin
      range_sel_r <= dhc_pkg::mode_t'(cfg_wdata);
    end
  end

  dhc_window u_window (
    .clk        (clk),
    .rst_n      (rst_n),
    .range_sel  (range_sel_r),
    .in_ch      (in_ch),
    .win_valid  (win_valid),
    .win_data   (win_data),
    .win_ready  (win_ready)
  );

  dhc_scale u_scale (
    .clk        (clk),
    .rst_n      (rst_n),
    .win_valid  (win_valid),
    .win_data   (win_data),
    .win_ready  (win_ready),
    .out_ch     (out_ch)
  );

  assign rgb_has_zero = (out_ch.red == '0) || (out_ch.green == '0) || (out_ch.blue == '0);
  assign rgb_has_full = (out_ch.red == dhc_pkg::CH_MAX) || (out_ch.green == dhc_pkg::CH_MAX) ||
                        (out_ch.blue == dhc_pkg::CH_MAX);
  assign rgb_is_black = ({out_ch.red, out_ch.green, out_ch.blue} == '0);

  // hue with full saturation: some channel is zero, and one is full unless black
  `DHC_ASSERT(a_min_zero, clk, rst_n, out_ch.valid |-> rgb_has_zero)
  `DHC_ASSERT(a_max_full, clk, rst_n, out_ch.valid |-> (rgb_has_full || rgb_is_black))
  `DHC_ASSERT_ALWAYS(a_rst_empty, clk, !rst_n |=> !out_ch.valid)

endmodule
